// File: src/pearson_correlation_rotated_assert.svh
// assertion macros used by the correlation back end (pcr_back)
`ifndef PEARSON_CORRELATION_ROTATED_ASSERT_SVH
`define PEARSON_CORRELATION_ROTATED_ASSERT_SVH

// same-cycle implication, checked on i_clk and disabled in reset
`define PCR_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("pcr assertion failed");

// next-cycle implication, checked on i_clk and disabled in reset
`define PCR_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("pcr assertion failed");

`endif

// File: src/pcr_pkg.sv
// shared constants and types of the correlation block
package pcr_pkg;

    localparam int ROT_W  = 12;   // rotation register width
    localparam int CORR_W = 16;   // Q1.15 coefficient width
    localparam int PCNT_W = 13;   // reported pair count width
    localparam int Q_W    = 15;   // fraction bits of the coefficient magnitude

    // control bits that travel with each queued pair
    typedef struct packed {
        logic last;
        logic drop;
    } t_item_ctl;

endpackage

// File: src/pcr_ram.sv
// generic single-write, single-read ram with registered read data
module pcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/pcr_front.sv
// input side: accepts pairs, marks those beyond capacity, queues them
module pcr_front import pcr_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_PAIRS    = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_a,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_b,
    input  logic                           i_last,
    input  logic                           i_pop,
    output logic                           o_head_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_head_a,
    output logic signed [SAMPLE_WIDTH-1:0] o_head_b,
    output t_item_ctl                      o_head_ctl
);

    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int QD  = 4;
    localparam int QAW = $clog2(QD);

    logic signed [SAMPLE_WIDTH-1:0] r_qa [QD];
    logic signed [SAMPLE_WIDTH-1:0] r_qb [QD];
    t_item_ctl                      r_qc [QD];
    logic [QAW-1:0]                 r_wp, r_rp;
    logic [QAW:0]                   r_fill, n_fill;
    logic [CW-1:0]                  r_fcnt;
    logic                           push;
    logic                           drop;

    assign o_in_stall = (r_fill == (QAW+1)'(QD));
    assign push       = i_in_valid && !o_in_stall;
    assign drop       = (r_fcnt == CW'(MAX_PAIRS));
    assign n_fill     = r_fill + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, i_pop};

    // pointers, fill level and per-set pair count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
            r_fcnt <= '0;
        end else begin
            r_fill <= n_fill;
            if (push) begin
                r_wp <= r_wp + 1'b1;
                if (i_last) begin
                    r_fcnt <= '0;
                end else if (!drop) begin
                    r_fcnt <= r_fcnt + 1'b1;
                end
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_qa[r_wp]      <= i_sample_a;
            r_qb[r_wp]      <= i_sample_b;
            r_qc[r_wp].last <= i_last;
            r_qc[r_wp].drop <= drop;
        end
    end

    assign o_head_valid = (r_fill != '0);
    assign o_head_a     = r_qa[r_rp];
    assign o_head_b     = r_qb[r_rp];
    assign o_head_ctl   = r_qc[r_rp];

endmodule

// File: src/pcr_mul.sv
// shift-add multiplier, one operand bit per cycle
module pcr_mul #(
    parameter int W = 58
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_x,
    input  logic [W-1:0]   i_y,
    output logic           o_done,
    output logic [2*W-1:0] o_prod
);

    localparam int NW = $clog2(W + 1);

    logic [2*W-1:0] r_x;
    logic [W-1:0]   r_y;
    logic [2*W-1:0] r_acc;
    logic [NW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    // sequencing of the bit steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == NW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // partial product accumulation
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= {{W{1'b0}}, i_x};
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_y[0]) begin
                r_acc <= r_acc + r_x;
            end
            r_x <= r_x << 1;
            r_y <= r_y >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: src/pcr_back.sv
// back end: stores pairs, accumulates sums, runs the correlation pass
`include "pearson_correlation_rotated_assert.svh"
module pcr_back import pcr_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_PAIRS    = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_head_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_head_a,
    input  logic signed [SAMPLE_WIDTH-1:0] i_head_b,
    input  t_item_ctl                      i_head_ctl,
    output logic                           o_pop,
    input  logic [ROT_W-1:0]               i_rotation,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [CORR_W-1:0]       o_correlation,
    output logic                           o_degenerate,
    output logic                           o_overflow,
    output logic [PCNT_W-1:0]              o_pair_count
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = $clog2(MAX_PAIRS + 1);
    localparam int AW   = $clog2(MAX_PAIRS);
    localparam int SUMW = SW + CW;
    localparam int SQW  = 2 * SW + CW;
    localparam int SABW = 2 * SW + CW;
    localparam int VW   = 2 * SW + 2 * CW;
    localparam int PW   = 2 * VW;
    localparam int EW   = PW + 2 * Q_W + 1;
    localparam int KW   = $clog2(Q_W);
    localparam int RBW  = $clog2(ROT_W);
    localparam int XW   = (CW > PCNT_W) ? CW : PCNT_W;

    typedef enum logic [7:0] {
        ST_LOAD = 8'b0000_0001,
        ST_ROT  = 8'b0000_0010,
        ST_SAB  = 8'b0000_0100,
        ST_MUL  = 8'b0000_1000,
        ST_SQA  = 8'b0001_0000,
        ST_SQB  = 8'b0010_0000,
        ST_SQC  = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } t_state;

    typedef enum logic [2:0] {
        MS_NSAA, MS_SASQ, MS_NSBB, MS_SBSQ, MS_NSAB, MS_SASB, MS_VAVB, MS_COV2
    } t_mstep;

    t_state                 r_state;
    // load stage
    logic                   r_ld_valid;
    logic signed [SW-1:0]   r_ld_a, r_ld_b;
    t_item_ctl              r_ld_ctl;
    logic [2*SW-1:0]        r_ld_sqa, r_ld_sqb;
    logic signed [2*SW-1:0] sq_a, sq_b;
    logic [CW-1:0]          r_cnt;
    logic signed [SUMW-1:0] r_sum_a, r_sum_b;
    logic [SQW-1:0]         r_sum_aa, r_sum_bb;
    logic                   r_dropped;
    // rotation reduction
    logic [RBW-1:0]         r_rbit;
    logic [CW-1:0]          r_rem, n_rem;
    logic [CW:0]            rem_sh;
    // cross-product pass
    logic [CW-1:0]          r_i, r_j;
    logic                   r_v1, r_v2;
    logic [SW-1:0]          rd_a, rd_b;
    logic signed [2*SW-1:0] r_prod;
    logic signed [SABW-1:0] r_sab;
    // product sequence
    t_mstep                 r_step;
    logic                   r_issued;
    logic [VW-1:0]          r_t, r_va, r_vb;
    logic signed [VW:0]     r_cov;
    logic [PW-1:0]          r_den, r_num;
    logic [VW-1:0]          mul_x, mul_y;
    logic                   mul_start, mul_done;
    logic [PW-1:0]          mul_prod;
    logic signed [VW+1:0]   cov_t, cov_p;
    logic [SUMW-1:0]        mag_sa, mag_sb;
    logic [SABW-1:0]        mag_sab;
    logic [VW-1:0]          mag_cov;
    // coefficient search
    logic [KW-1:0]          r_k;
    logic [EW-1:0]          r_p, r_qd, r_cand, num_sh;
    logic [Q_W-1:0]         r_q;
    // output register
    logic                   r_out_valid;
    logic [CORR_W-1:0]      r_out_corr;
    logic                   r_out_degen, r_out_ovf;
    logic [PCNT_W-1:0]      r_out_cnt;
    logic                   degen, out_load;
    logic [CORR_W-1:0]      corr_mag;
    logic [XW-1:0]          cnt_x;

    // sample rams and multiplier
    pcr_ram #(.WIDTH(SW), .DEPTH(MAX_PAIRS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (r_ld_valid && !r_ld_ctl.drop),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_ld_a),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (rd_a)
    );

    pcr_ram #(.WIDTH(SW), .DEPTH(MAX_PAIRS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (r_ld_valid && !r_ld_ctl.drop),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_ld_b),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (rd_b)
    );

    pcr_mul #(.W(VW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // queue pop while loading, held off behind a set's final pair
    assign o_pop = i_head_valid && (r_state == ST_LOAD) && !(r_ld_valid && r_ld_ctl.last);
    assign sq_a  = i_head_a * i_head_a;
    assign sq_b  = i_head_b * i_head_b;

    // magnitudes of the signed sums
    assign mag_sa  = r_sum_a[SUMW-1] ? SUMW'(-r_sum_a) : SUMW'(r_sum_a);
    assign mag_sb  = r_sum_b[SUMW-1] ? SUMW'(-r_sum_b) : SUMW'(r_sum_b);
    assign mag_sab = r_sab[SABW-1] ? SABW'(-r_sab) : SABW'(r_sab);
    assign mag_cov = r_cov[VW] ? VW'(-r_cov) : r_cov[VW-1:0];

    // rotation remainder step
    assign rem_sh = {r_rem, i_rotation[r_rbit]};
    assign n_rem  = (rem_sh >= {1'b0, r_cnt}) ? CW'(rem_sh - {1'b0, r_cnt}) : rem_sh[CW-1:0];

    // signed covariance terms
    always_comb begin
        cov_t = {2'b00, r_t};
        if (r_sab[SABW-1]) begin
            cov_t = -cov_t;
        end
        cov_p = {2'b00, mul_prod[VW-1:0]};
        if (r_sum_a[SUMW-1] != r_sum_b[SUMW-1]) begin
            cov_p = -cov_p;
        end
    end

    // multiplier operand selection
    assign mul_start = (r_state == ST_MUL) && !r_issued;
    always_comb begin
        case (r_step)
            MS_NSAA: begin mul_x = VW'(r_cnt);  mul_y = VW'(r_sum_aa); end
            MS_SASQ: begin mul_x = VW'(mag_sa); mul_y = VW'(mag_sa);   end
            MS_NSBB: begin mul_x = VW'(r_cnt);  mul_y = VW'(r_sum_bb); end
            MS_SBSQ: begin mul_x = VW'(mag_sb); mul_y = VW'(mag_sb);   end
            MS_NSAB: begin mul_x = VW'(r_cnt);  mul_y = VW'(mag_sab);  end
            MS_SASB: begin mul_x = VW'(mag_sa); mul_y = VW'(mag_sb);   end
            MS_VAVB: begin mul_x = r_va;        mul_y = r_vb;          end
            MS_COV2: begin mul_x = mag_cov;     mul_y = mag_cov;       end
            default: begin mul_x = '0;          mul_y = '0;            end
        endcase
    end

    assign degen    = (r_va == '0) || (r_vb == '0);
    assign num_sh   = EW'({r_num, {(2 * Q_W){1'b0}}});
    assign corr_mag = CORR_W'(r_q);
    assign out_load = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign cnt_x    = XW'(r_cnt);

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_ld_valid  <= 1'b0;
            r_cnt       <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_sum_aa    <= '0;
            r_sum_bb    <= '0;
            r_dropped   <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_issued    <= 1'b0;
            r_step      <= MS_NSAA;
            r_out_valid <= 1'b0;
        end else begin
            r_ld_valid <= o_pop;
            if (o_pop) begin
                r_ld_a   <= i_head_a;
                r_ld_b   <= i_head_b;
                r_ld_ctl <= i_head_ctl;
                r_ld_sqa <= sq_a;
                r_ld_sqb <= sq_b;
            end
            // output register fill and drain
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_LOAD: begin
                    if (r_ld_valid) begin
                        if (r_ld_ctl.drop) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_cnt    <= r_cnt + 1'b1;
                            r_sum_a  <= r_sum_a + SUMW'(r_ld_a);
                            r_sum_b  <= r_sum_b + SUMW'(r_ld_b);
                            r_sum_aa <= r_sum_aa + SQW'(r_ld_sqa);
                            r_sum_bb <= r_sum_bb + SQW'(r_ld_sqb);
                        end
                        if (r_ld_ctl.last) begin
                            r_state <= ST_ROT;
                            r_rbit  <= RBW'(ROT_W - 1);
                            r_rem   <= '0;
                        end
                    end
                end
                ST_ROT: begin
                    r_rem  <= n_rem;
                    r_rbit <= r_rbit - 1'b1;
                    if (r_rbit == '0) begin
                        r_state <= ST_SAB;
                        r_i     <= '0;
                        r_j     <= n_rem;
                        r_sab   <= '0;
                        r_v1    <= 1'b0;
                        r_v2    <= 1'b0;
                    end
                end
                ST_SAB: begin
                    r_v1 <= (r_i != r_cnt);
                    r_v2 <= r_v1;
                    if (r_i != r_cnt) begin
                        r_i <= r_i + 1'b1;
                        r_j <= (r_j == r_cnt - 1'b1) ? '0 : r_j + 1'b1;
                    end
                    if (r_v1) begin
                        r_prod <= $signed(rd_a) * $signed(rd_b);
                    end
                    if (r_v2) begin
                        r_sab <= r_sab + SABW'(r_prod);
                    end
                    if ((r_i == r_cnt) && !r_v1 && !r_v2) begin
                        r_state  <= ST_MUL;
                        r_step   <= MS_NSAA;
                        r_issued <= 1'b0;
                    end
                end
                ST_MUL: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end
                    if (mul_done) begin
                        r_issued <= 1'b0;
                        case (r_step)
                            MS_NSAA: r_t   <= mul_prod[VW-1:0];
                            MS_SASQ: r_va  <= r_t - mul_prod[VW-1:0];
                            MS_NSBB: r_t   <= mul_prod[VW-1:0];
                            MS_SBSQ: r_vb  <= r_t - mul_prod[VW-1:0];
                            MS_NSAB: r_t   <= mul_prod[VW-1:0];
                            MS_SASB: r_cov <= (VW+1)'(cov_t - cov_p);
                            MS_VAVB: r_den <= mul_prod;
                            MS_COV2: r_num <= mul_prod;
                            default: r_t   <= r_t;
                        endcase
                        if (r_step == MS_COV2) begin
                            r_p  <= '0;
                            r_qd <= '0;
                            r_q  <= '0;
                            r_k  <= KW'(Q_W - 1);
                            r_state <= degen ? ST_EMIT : ST_SQA;
                        end else begin
                            r_step <= t_mstep'(r_step + 3'd1);
                        end
                    end
                end
                ST_SQA: begin
                    r_cand  <= r_p + (r_qd << ((KW+1)'(r_k) + 1'b1));
                    r_state <= ST_SQB;
                end
                ST_SQB: begin
                    r_cand  <= r_cand + (EW'(r_den) << {r_k, 1'b0});
                    r_state <= ST_SQC;
                end
                ST_SQC: begin
                    if (r_cand <= num_sh) begin
                        r_p      <= r_cand;
                        r_qd     <= r_qd + (EW'(r_den) << r_k);
                        r_q[r_k] <= 1'b1;
                    end
                    r_k     <= r_k - 1'b1;
                    r_state <= (r_k == '0) ? ST_EMIT : ST_SQA;
                end
                ST_EMIT: begin
                    if (out_load) begin
                        r_out_corr  <= (r_cov[VW] && (r_q != '0)) ? -corr_mag : corr_mag;
                        r_out_degen <= degen;
                        r_out_ovf   <= r_dropped;
                        r_out_cnt   <= cnt_x[PCNT_W-1:0];
                        r_cnt       <= '0;
                        r_sum_a     <= '0;
                        r_sum_b     <= '0;
                        r_sum_aa    <= '0;
                        r_sum_bb    <= '0;
                        r_dropped   <= 1'b0;
                        r_state     <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_correlation = r_out_corr;
    assign o_degenerate  = r_out_degen;
    assign o_overflow    = r_out_ovf;
    assign o_pair_count  = r_out_cnt;

    // checks on the sequencer
    `PCR_ASSERT_IMP(a_pop_in_load, o_pop, r_state == ST_LOAD)
    `PCR_ASSERT_IMP(a_keep_has_room, r_ld_valid && !r_ld_ctl.drop, r_cnt < CW'(MAX_PAIRS))
    `PCR_ASSERT_IMP(a_rot_index_in_set, r_state == ST_SAB, (r_j < r_cnt) && (r_i <= r_cnt))
    `PCR_ASSERT_IMP(a_mul_done_in_mul, mul_done, r_state == ST_MUL)
    `PCR_ASSERT_NXT(a_emit_holds, (r_state == ST_EMIT) && r_out_valid && i_out_stall,
                    r_state == ST_EMIT)

endmodule

// File: src/pearson_correlation_rotated.sv
// Pearson correlation of two buffered series with series b rotated.
// Input channel: i_in_valid / o_in_stall carry one pair (i_sample_a,
// i_sample_b, i_last) per transaction; i_last closes the data set.
// Output channel: o_out_valid / i_out_stall carry one result per set:
// o_correlation (Q1.15, truncated toward zero, +1.0 gives 32767),
// o_degenerate, o_overflow and o_pair_count.
// Pairs load at one per cycle through a four-entry queue while the block
// is in its load phase; pairs beyond MAX_PAIRS are dropped and flagged.
// After the final pair the block reduces the rotation modulo the pair
// count bit by bit, runs the cross-product pass (one ram read per series
// per cycle), forms eight products of VW-bit operands in the shift-add
// multiplier (VW = 2*SAMPLE_WIDTH + 2*clog2(MAX_PAIRS+1), 58 by default)
// and runs the coefficient bit search; no pairs load during that pass.
// i_cfg_we writes the 12-bit rotation; write it only while idle.
// Reset (i_rst_n low, synchronous) empties the queue, clears sums,
// counters and rotation. A stalled result holds on the outputs, and the
// block holds the next set's result back until the stalled one is taken.
module pearson_correlation_rotated import pcr_pkg::*; #(
    parameter int MAX_PAIRS    = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_a,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_b,
    input  logic                           i_last,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [CORR_W-1:0]       o_correlation,
    output logic                           o_degenerate,
    output logic                           o_overflow,
    output logic [PCNT_W-1:0]              o_pair_count,
    input  logic                           i_cfg_we,
    input  logic [ROT_W-1:0]               i_cfg_wdata
);

    logic                           head_valid;
    logic signed [SAMPLE_WIDTH-1:0] head_a, head_b;
    t_item_ctl                      head_ctl;
    logic                           pop;
    logic [ROT_W-1:0]               r_rotation;

    // rotation register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= '0;
        end else if (i_cfg_we) begin
            r_rotation <= i_cfg_wdata;
        end
    end

    pcr_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .MAX_PAIRS(MAX_PAIRS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_a   (i_sample_a),
        .i_sample_b   (i_sample_b),
        .i_last       (i_last),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_a     (head_a),
        .o_head_b     (head_b),
        .o_head_ctl   (head_ctl)
    );

    pcr_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .MAX_PAIRS(MAX_PAIRS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head_a      (head_a),
        .i_head_b      (head_b),
        .i_head_ctl    (head_ctl),
        .o_pop         (pop),
        .i_rotation    (r_rotation),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_correlation (o_correlation),
        .o_degenerate  (o_degenerate),
        .o_overflow    (o_overflow),
        .o_pair_count  (o_pair_count)
    );

endmodule
